[src/iira_pkg.sv]
package iira_pkg;

   localparam int DEPTH   = 16;
   localparam int WIDTH   = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic              load;
      logic              do_append;
      logic              do_insert;
      logic              do_remove;
      logic              do_read;
      logic              do_write;
      logic              done;
      logic [STAT_W-1:0] status;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             pos_le_count;
      logic             pos_lt_count;
   } dp_stat_type;

endpackage

[src/iira_datapath.sv]
module iira_datapath
   import iira_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        ctl,
   output dp_stat_type        stat,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [IDX_W-1:0]   req_position,
   input  logic [WIDTH-1:0]   req_item_value,
   output logic [WIDTH-1:0]   rsp_read_value,
   output logic [CNT_W-1:0]   rsp_entry_count,
   output logic [STAT_W-1:0]  rsp_status
);

   logic [WIDTH-1:0]  entries_ff [DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [IDX_W-1:0]  pos_ff;
   logic [WIDTH-1:0]  val_ff;
   logic [WIDTH-1:0]  rd_value_ff;
   logic [CNT_W-1:0]  rd_count_ff;
   logic [STAT_W-1:0] rd_status_ff;
   logic [CNT_W-1:0]  pos_ext;

   assign pos_ext = {{(CNT_W-IDX_W){1'b0}}, pos_ff};

   assign stat.cmd          = cmd_ff;
   assign stat.full         = (count_ff == CNT_W'(DEPTH));
   assign stat.pos_le_count = (pos_ext <= count_ff);
   assign stat.pos_lt_count = (pos_ext < count_ff);

   always_comb begin
      count_in = count_ff;
      if (ctl.do_append || ctl.do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_cmd;
         pos_ff <= req_position;
         val_ff <= req_item_value;
      end
      if (ctl.done) begin
         rd_value_ff  <= ctl.do_read ? entries_ff[pos_ff] : '0;
         rd_count_ff  <= count_in;
         rd_status_ff <= ctl.status;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.do_append) begin
         entries_ff[count_ff[IDX_W-1:0]] <= val_ff;
      end else if (ctl.do_insert) begin
         for (int i = 1; i < DEPTH; i++) begin
            if (i > int'(pos_ff)) begin
               entries_ff[i] <= entries_ff[i-1];
            end
         end
         entries_ff[pos_ff] <= val_ff;
      end else if (ctl.do_remove) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (i >= int'(pos_ff)) begin
               entries_ff[i] <= entries_ff[i+1];
            end
         end
      end else if (ctl.do_write) begin
         entries_ff[pos_ff] <= val_ff;
      end
   end

   assign rsp_read_value  = rd_value_ff;
   assign rsp_entry_count = rd_count_ff;
   assign rsp_status      = rd_status_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("Entry count exceeds the capacity.");

   assert property (@(posedge clock) disable iff (reset)
      (ctl.do_append || ctl.do_insert) |-> !stat.full)
      else $error("Entry added to a full list.");

   assert property (@(posedge clock) disable iff (reset)
      (ctl.do_remove || ctl.do_read || ctl.do_write) |-> stat.pos_lt_count)
      else $error("Indexed access beyond the entry count.");

endmodule

[src/iira_controller.sv]
module iira_controller
   import iira_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_strobe,
   input  dp_stat_type stat,
   output ctl_cmd_type ctl
);

   typedef enum logic {
      IDLE,
      EXEC
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   always_comb begin
      ctl           = '0;
      ctl.status    = ST_OK;
      ctl.load      = (state_ff == IDLE) && start;
      if (state_ff == EXEC) begin
         ctl.done = 1'b1;
         unique case (stat.cmd)
            CMD_APPEND: begin
               if (stat.full) begin
                  ctl.status = ST_FULL;
               end else begin
                  ctl.do_append = 1'b1;
               end
            end
            CMD_INSERT: begin
               if (stat.full) begin
                  ctl.status = ST_FULL;
               end else if (!stat.pos_le_count) begin
                  ctl.status = ST_RANGE;
               end else begin
                  ctl.do_insert = 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (!stat.pos_lt_count) begin
                  ctl.status = ST_RANGE;
               end else begin
                  ctl.do_remove = 1'b1;
               end
            end
            CMD_READ: begin
               if (!stat.pos_lt_count) begin
                  ctl.status = ST_RANGE;
               end else begin
                  ctl.do_read = 1'b1;
               end
            end
            CMD_WRITE: begin
               if (!stat.pos_lt_count) begin
                  ctl.status = ST_RANGE;
               end else begin
                  ctl.do_write = 1'b1;
               end
            end
            default: begin
               ctl.status = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               strobe_ff <= 1'b0;
               if (start) begin
                  state_ff <= EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            EXEC: begin
               state_ff  <= IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b1;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("Result shown while a transaction is in progress.");

   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("Accepted transaction did not raise busy.");

   assert property (@(posedge clock) disable iff (reset) busy |=> (!busy && rsp_strobe))
      else $error("Transaction did not complete in one execute cycle.");

endmodule

[src/indexed_insert_remove_array.sv]
// Channel   Handshake                 Payload
// request   start high, busy low      req_cmd, req_position, req_item_value
// response  rsp_strobe for one cycle  rsp_read_value, rsp_entry_count, rsp_status
//
// Each transaction first captures the request and then executes it in the EXEC state,
// with the affected entries shifting in parallel during execution.
// The response appears in the cycle after execution, when busy is already low, so a new
// request may be issued in that same cycle. The receiver cannot stall the response.
// Synchronous reset empties the list; entry contents are not cleared.
module indexed_insert_remove_array
   import iira_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [IDX_W-1:0]  req_position,
   input  logic [WIDTH-1:0]  req_item_value,
   output logic              rsp_strobe,
   output logic [WIDTH-1:0]  rsp_read_value,
   output logic [CNT_W-1:0]  rsp_entry_count,
   output logic [STAT_W-1:0] rsp_status
);

   ctl_cmd_type ctl;
   dp_stat_type stat;

   iira_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .ctl        (ctl)
   );

   iira_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

endmodule
